### sv/vex3_instruction_length_decode_core_macros.svh
// Assertion macros shared by the length decoder.
`ifndef VEX3_INSTRUCTION_LENGTH_DECODE_CORE_MACROS_SVH
`define VEX3_INSTRUCTION_LENGTH_DECODE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VEX3LD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VEX3LD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/vex3ld_pkg.sv
package vex3ld_pkg;

  localparam logic [7:0] LeadC4   = 8'hC4;
  localparam logic [2:0] RmSib    = 3'b100;
  localparam logic [2:0] RmDisp32 = 3'b101;
  localparam logic [2:0] RxbNone  = 3'b111;
  localparam logic [4:0] Map2     = 5'h02;
  localparam logic [4:0] Map3     = 5'h03;
  localparam logic [3:0] MinPrefixBytes = 4'd5;
  localparam logic [3:0] MinSibBytes    = 4'd6;
  localparam logic [3:0] LenBase        = 4'd4;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOT_C4 = 2'd1,
    ST_UNSUP  = 2'd2,
    ST_SHORT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MOD_IND    = 2'd0,
    MOD_DISP8  = 2'd1,
    MOD_DISP32 = 2'd2,
    MOD_REG    = 2'd3
  } mod_e;

  typedef struct packed {
    logic hit;
    logic w;
    logic reg_ok;
    logic imm;
  } lookup_t;

  // First stage: prefix checks done, ModRM still to be sized.
  typedef struct packed {
    status_e    status;
    logic       reg_ok;
    logic       imm;
    mod_e       mode;
    logic [2:0] rm;
    logic       sib_disp;
    logic       has_sib;
  } s1_t;

  // Second stage: operand size known.
  typedef struct packed {
    status_e    status;
    logic [2:0] opsz;
    logic       imm;
  } s2_t;

  function automatic lookup_t vex_lookup(logic [4:0] map, logic [7:0] op);
    lookup_t r;
    r = '{hit: 1'b0, w: 1'b0, reg_ok: 1'b1, imm: 1'b0};
    if (map == Map2) begin
      unique case (op)
        8'h13, 8'h18, 8'h36, 8'h58, 8'h78, 8'h79, 8'hF7: r.hit = 1'b1;
        8'h5A, 8'h8C, 8'h90: begin
          r.hit    = 1'b1;
          r.reg_ok = 1'b0;
        end
        default: r.hit = 1'b0;
      endcase
    end else if (map == Map3) begin
      unique case (op)
        8'h00: begin
          r.hit = 1'b1;
          r.w   = 1'b1;
          r.imm = 1'b1;
        end
        8'h1D, 8'h38, 8'h39, 8'h46: begin
          r.hit = 1'b1;
          r.imm = 1'b1;
        end
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

### sv/vex3ld_if.sv
interface vex3ld_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] lead_byte;
  logic [7:0] vex_byte1;
  logic [7:0] vex_byte2;
  logic [7:0] opcode_byte;
  logic [7:0] modrm;
  logic [7:0] sib_byte;
  logic [3:0] available_bytes;

  modport source (output valid, lead_byte, vex_byte1, vex_byte2, opcode_byte,
                  modrm, sib_byte, available_bytes, input ready);
  modport sink   (input valid, lead_byte, vex_byte1, vex_byte2, opcode_byte,
                  modrm, sib_byte, available_bytes, output ready);
endinterface

interface vex3ld_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] length;
  logic [1:0] status;

  modport source (output valid, length, status, input ready);
  modport sink   (input valid, length, status, output ready);
endinterface

### sv/vex3ld_classify.sv
module vex3ld_classify
  import vex3ld_pkg::*;
(
  input  logic [7:0] lead_byte_i,
  input  logic [7:0] vex_byte1_i,
  input  logic [7:0] vex_byte2_i,
  input  logic [7:0] opcode_byte_i,
  input  logic [7:0] modrm_i,
  input  logic [7:0] sib_byte_i,
  input  logic [3:0] available_bytes_i,
  output s1_t        stage_o
);

  lookup_t lk;

  assign lk = vex_lookup(vex_byte1_i[4:0], opcode_byte_i);

  always_comb begin
    stage_o.reg_ok   = lk.reg_ok;
    stage_o.imm      = lk.imm;
    stage_o.mode     = mod_e'(modrm_i[7:6]);
    stage_o.rm       = modrm_i[2:0];
    stage_o.sib_disp = (sib_byte_i[2:0] == RmDisp32);
    stage_o.has_sib  = (available_bytes_i >= MinSibBytes);
    priority if (available_bytes_i == 4'd0) begin
      stage_o.status = ST_SHORT;
    end else if (lead_byte_i != LeadC4) begin
      stage_o.status = ST_NOT_C4;
    end else if (available_bytes_i < MinPrefixBytes) begin
      stage_o.status = ST_SHORT;
    end else if (!lk.hit || (vex_byte1_i[7:5] != RxbNone) || (vex_byte2_i[7] != lk.w)) begin
      stage_o.status = ST_UNSUP;
    end else begin
      stage_o.status = ST_OK;
    end
  end

endmodule

### sv/vex3_instruction_length_decode_core.sv
// Length decoder for three-byte VEX (C4) instructions in 32-bit code.
// The item channel carries the first six instruction bytes and the count
// of valid bytes; the result channel returns the total length and a status.
// A status other than ok always comes with a length of zero.
// The block is a three-stage pipeline: prefix and opcode checks, ModRM
// sizing, then the final length in the output register. A result is
// registered in each stage in turn, and while the receiver keeps ready
// high one item can transfer every cycle, so throughput is one
// instruction per clock.
// Each stage holds its own valid bit and advances when the stage after it
// is empty or moving, so a stalled receiver only backs up the pipeline and
// bubbles are squeezed out; nothing is dropped or repeated.
// Reset clears all valid bits; the data registers are not reset, and the
// block is ready in the first cycle after reset is released.
`include "vex3_instruction_length_decode_core_macros.svh"

module vex3_instruction_length_decode_core
  import vex3ld_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  vex3ld_item_if.sink     item_i,
  vex3ld_result_if.source result_o
);

  s1_t        s1_d, s1_q;
  s2_t        s2_d, s2_q;
  logic       v1_q, v2_q, v3_q;
  logic       adv1, adv2, adv3;
  logic [3:0] len_d, len_q;
  status_e    st_q;

  vex3ld_classify u_classify (
    .lead_byte_i       (item_i.lead_byte),
    .vex_byte1_i       (item_i.vex_byte1),
    .vex_byte2_i       (item_i.vex_byte2),
    .opcode_byte_i     (item_i.opcode_byte),
    .modrm_i           (item_i.modrm),
    .sib_byte_i        (item_i.sib_byte),
    .available_bytes_i (item_i.available_bytes),
    .stage_o           (s1_d)
  );

  assign adv3 = !v3_q || result_o.ready;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign item_i.ready = adv1;

  always_comb begin
    s2_d.status = s1_q.status;
    s2_d.imm    = s1_q.imm;
    s2_d.opsz   = 3'd0;
    if (s1_q.status == ST_OK) begin
      unique case (s1_q.mode)
        MOD_IND: begin
          if (s1_q.rm == RmSib) begin
            if (!s1_q.has_sib) begin
              s2_d.status = ST_SHORT;
            end else begin
              s2_d.opsz = s1_q.sib_disp ? 3'd6 : 3'd2;
            end
          end else if (s1_q.rm == RmDisp32) begin
            s2_d.opsz = 3'd5;
          end else begin
            s2_d.opsz = 3'd1;
          end
        end
        MOD_DISP8:  s2_d.opsz = (s1_q.rm == RmSib) ? 3'd3 : 3'd2;
        MOD_DISP32: s2_d.opsz = (s1_q.rm == RmSib) ? 3'd6 : 3'd5;
        MOD_REG: begin
          if (s1_q.reg_ok) begin
            s2_d.opsz = 3'd1;
          end else begin
            s2_d.status = ST_UNSUP;
          end
        end
        default: s2_d.status = ST_UNSUP;
      endcase
    end
  end

  assign len_d = (s2_q.status == ST_OK)
               ? (LenBase + {1'b0, s2_q.opsz} + {3'b000, s2_q.imm}) : 4'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= item_i.valid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) s1_q <= s1_d;
    if (adv2) s2_q <= s2_d;
    if (adv3) begin
      len_q <= len_d;
      st_q  <= s2_q.status;
    end
  end

  assign result_o.valid  = v3_q;
  assign result_o.length = len_q;
  assign result_o.status = st_q;

  `VEX3LD_ASSERT_NOW(a_zero_len_on_error, v3_q && (st_q != ST_OK), len_q == 4'd0, "error result with nonzero length")
  `VEX3LD_ASSERT_NOW(a_len_range, v3_q && (st_q == ST_OK), (len_q >= 4'd5) && (len_q <= 4'd11), "decoded length out of range")
  `VEX3LD_ASSERT_NEXT(a_accept_fills_s1, item_i.valid && item_i.ready, v1_q, "transfer did not reach first stage")

endmodule

### bench/vex3_instruction_length_decode_core_test.sv
`timescale 1ns / 1ps

module vex3_instruction_length_decode_core_test;
  import vex3ld_pkg::*;

  localparam int RandomItems = 850;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam int TableSize   = 15;

  localparam logic [55:0] Map2RegOps =
    {8'h13, 8'h18, 8'h36, 8'h58, 8'h78, 8'h79, 8'hF7};
  localparam logic [23:0] Map2MemOps    = {8'h5A, 8'h8C, 8'h90};
  localparam logic [7:0]  Map3WideOp    = 8'h00;
  localparam logic [31:0] Map3NarrowOps = {8'h1D, 8'h38, 8'h39, 8'h46};
  localparam logic [7:0]  VexW0         = 8'h79;
  localparam logic [7:0]  VexW1         = 8'hF9;

  typedef struct packed {
    logic [7:0] lead_byte;
    logic [7:0] vex_byte1;
    logic [7:0] vex_byte2;
    logic [7:0] opcode_byte;
    logic [7:0] modrm;
    logic [7:0] sib_byte;
    logic [3:0] available_bytes;
  } vex_item_t;

  typedef struct packed {
    logic [3:0] total_len;
    status_e    status;
  } decoded_t;

  class length_scoreboard;
    decoded_t expected_lengths[$];
    int       errors = 0;

    function bit op_listed(logic [7:0] op, logic [55:0] list, int count);
      for (int i = 0; i < count; i++) begin
        if (list[i*8 +: 8] == op) return 1'b1;
      end
      return 1'b0;
    endfunction

    function decoded_t decode_length(vex_item_t it);
      decoded_t   d;
      logic       known;
      logic       want_w;
      logic       reg_allowed;
      logic       has_imm;
      logic [2:0] operand;
      logic [2:0] rm;
      d.total_len = 4'd0;
      d.status    = ST_OK;
      known       = 1'b0;
      want_w      = 1'b0;
      reg_allowed = 1'b1;
      has_imm     = 1'b0;
      operand     = 3'd0;
      rm          = it.modrm[2:0];
      if (it.vex_byte1[4:0] == Map2) begin
        if (op_listed(it.opcode_byte, 56'(Map2RegOps), 7)) begin
          known = 1'b1;
        end else if (op_listed(it.opcode_byte, 56'(Map2MemOps), 3)) begin
          known       = 1'b1;
          reg_allowed = 1'b0;
        end
      end else if (it.vex_byte1[4:0] == Map3) begin
        has_imm = 1'b1;
        if (it.opcode_byte == Map3WideOp) begin
          known  = 1'b1;
          want_w = 1'b1;
        end else if (op_listed(it.opcode_byte, 56'(Map3NarrowOps), 4)) begin
          known = 1'b1;
        end
      end
      if (it.available_bytes == 4'd0) begin
        d.status = ST_SHORT;
      end else if (it.lead_byte != LeadC4) begin
        d.status = ST_NOT_C4;
      end else if (it.available_bytes < MinPrefixBytes) begin
        d.status = ST_SHORT;
      end else if (!known || it.vex_byte1[7:5] != RxbNone || it.vex_byte2[7] != want_w) begin
        d.status = ST_UNSUP;
      end else begin
        case (mod_e'(it.modrm[7:6]))
          MOD_IND: begin
            if (rm == RmSib) begin
              if (it.available_bytes < MinSibBytes) d.status = ST_SHORT;
              else operand = (it.sib_byte[2:0] == RmDisp32) ? 3'd6 : 3'd2;
            end else if (rm == RmDisp32) begin
              operand = 3'd5;
            end else begin
              operand = 3'd1;
            end
          end
          MOD_DISP8:  operand = (rm == RmSib) ? 3'd3 : 3'd2;
          MOD_DISP32: operand = (rm == RmSib) ? 3'd6 : 3'd5;
          default: begin
            if (reg_allowed) operand = 3'd1;
            else d.status = ST_UNSUP;
          end
        endcase
        if (d.status == ST_OK) d.total_len = LenBase + {1'b0, operand} + {3'b000, has_imm};
      end
      return d;
    endfunction

    function void note_item(vex_item_t it);
      expected_lengths.push_back(decode_length(it));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [3:0] total_len, logic [1:0] status);
      decoded_t want;
      if (expected_lengths.size() == 0) begin
        report($sformatf("unexpected result length %0d status %0d", total_len, status));
      end else begin
        want = expected_lengths.pop_front();
        if (total_len !== want.total_len)
          report($sformatf("length %0d, expected %0d", total_len, want.total_len));
        if (status !== want.status)
          report($sformatf("status %0d, expected %0d", status, want.status));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycle_count;
  int   stall_left;
  int   stall_mode;
  int   stall_phase;
  logic [7:0] stall_mask;

  vex3ld_item_if   item_bus ();
  vex3ld_result_if result_bus ();

  length_scoreboard board = new;

  vex3_instruction_length_decode_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  always #5 clk_i = ~clk_i;

  function automatic void table_entry(input int idx, output logic [4:0] map,
                                      output logic [7:0] op, output logic w);
    w = 1'b0;
    if (idx < 7) begin
      map = Map2;
      op  = Map2RegOps[idx*8 +: 8];
    end else if (idx < 10) begin
      map = Map2;
      op  = Map2MemOps[(idx-7)*8 +: 8];
    end else if (idx == 10) begin
      map = Map3;
      op  = Map3WideOp;
      w   = 1'b1;
    end else begin
      map = Map3;
      op  = Map3NarrowOps[(idx-11)*8 +: 8];
    end
  endfunction

  function automatic vex_item_t vex_item(logic [7:0] lead, logic [7:0] b1, logic [7:0] b2,
                                         logic [7:0] op, logic [7:0] modrm,
                                         logic [7:0] sib, logic [3:0] avail);
    vex_item_t it;
    it = '{lead, b1, b2, op, modrm, sib, avail};
    return it;
  endfunction

  function automatic vex_item_t random_item();
    vex_item_t  it;
    logic [4:0] map;
    logic [7:0] op;
    logic       w;
    int         roll;
    it.lead_byte       = 8'($urandom);
    it.vex_byte1       = 8'($urandom);
    it.vex_byte2       = 8'($urandom);
    it.opcode_byte     = 8'($urandom);
    it.modrm           = 8'($urandom);
    it.sib_byte        = 8'($urandom);
    it.available_bytes = 4'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      table_entry($urandom_range(0, TableSize - 1), map, op, w);
      if (roll >= 3) it.lead_byte = LeadC4;
      it.vex_byte1 = {($urandom_range(0, 15) == 0) ? 3'($urandom) : RxbNone, map};
      if ($urandom_range(0, 19) != 0) it.opcode_byte = op;
      it.vex_byte2[7] = ($urandom_range(0, 19) == 0) ? ~w : w;
      if ($urandom_range(0, 9) != 0) it.available_bytes = 4'($urandom_range(5, 15));
    end
    return it;
  endfunction

  task automatic send_item(input vex_item_t it);
    @(negedge clk_i);
    item_bus.valid           <= 1'b1;
    item_bus.lead_byte       <= it.lead_byte;
    item_bus.vex_byte1       <= it.vex_byte1;
    item_bus.vex_byte2       <= it.vex_byte2;
    item_bus.opcode_byte     <= it.opcode_byte;
    item_bus.modrm           <= it.modrm;
    item_bus.sib_byte        <= it.sib_byte;
    item_bus.available_bytes <= it.available_bytes;
    do @(posedge clk_i); while (!(item_bus.valid && item_bus.ready));
  endtask

  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      item_bus.valid       <= 1'b0;
      item_bus.lead_byte   <= 8'($urandom);
      item_bus.opcode_byte <= 8'($urandom);
    end
  endtask

  task automatic wait_drained();
    idle_sender(1);
    while (board.expected_lengths.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    logic [4:0] map;
    logic [7:0] op;
    logic       w;
    send_item(vex_item(LeadC4, {RxbNone, Map2}, VexW0, 8'h13, 8'hC0, 8'h00, 4'd0));
    send_item(vex_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd15));
    send_item(vex_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 4'd15));
    send_item(vex_item(LeadC4, {RxbNone, Map2}, VexW0, 8'h13, 8'hC0, 8'h00, 4'd4));
    send_item(vex_item(LeadC4, {RxbNone, Map2}, VexW0, 8'h5A, 8'hC1, 8'h00, 4'd15));
    send_item(vex_item(LeadC4, {RxbNone, Map3}, VexW0, Map3WideOp, 8'hC0, 8'h00, 4'd15));
    send_item(vex_item(LeadC4, {RxbNone, Map3}, VexW1, 8'h46, 8'hC0, 8'h00, 4'd15));
    send_item(vex_item(LeadC4, {3'b011, Map2}, VexW0, 8'h13, 8'hC0, 8'h00, 4'd15));
    send_item(vex_item(LeadC4, 8'hE0, VexW0, 8'h13, 8'hC0, 8'h00, 4'd15));
    send_item(vex_item(LeadC4, 8'hFF, VexW0, 8'h13, 8'hC0, 8'h00, 4'd15));
    send_item(vex_item(LeadC4, {RxbNone, Map2}, VexW0, 8'h13, 8'h04, 8'h25, 4'd5));
    send_item(vex_item(LeadC4, {RxbNone, Map2}, VexW0, 8'h13, 8'h04, 8'h25, 4'd6));
    send_item(vex_item(LeadC4, {RxbNone, Map2}, VexW0, 8'h18, 8'h3C, 8'hF8, 4'd6));
    send_item(vex_item(LeadC4, {RxbNone, Map2}, VexW0, 8'h8C, 8'h05, 8'h00, 4'd5));
    send_item(vex_item(LeadC4, {RxbNone, Map3}, VexW0, 8'h1D, 8'hBC, 8'h00, 4'd15));
    for (int i = 0; i < TableSize; i++) begin
      table_entry(i, map, op, w);
      send_item(vex_item(LeadC4, {RxbNone, map}, w ? VexW1 : VexW0, op,
                         {2'(i), 3'(i), 3'(i + 3)}, 8'(i * 17), 4'd15));
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_mask  = 8'($urandom);
      stall_left  = $urandom_range(16, 96);
      stall_phase = 0;
    end else begin
      stall_left  = stall_left - 1;
      stall_phase = stall_phase + 1;
    end
    case (stall_mode)
      0:       result_bus.ready <= 1'b1;
      1:       result_bus.ready <= stall_mask[stall_phase % 8];
      2:       result_bus.ready <= ($urandom_range(0, 3) != 0);
      default: result_bus.ready <= (stall_phase >= int'(stall_mask[3:0]));
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_bus.valid && item_bus.ready)
        board.note_item(vex_item(item_bus.lead_byte, item_bus.vex_byte1, item_bus.vex_byte2,
                                 item_bus.opcode_byte, item_bus.modrm,
                                 item_bus.sib_byte, item_bus.available_bytes));
      if (result_bus.valid && result_bus.ready)
        board.check_result(result_bus.length, result_bus.status);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int burst_left;
    clk_i                    = 1'b0;
    rst_ni                   = 1'b0;
    stall_left               = 0;
    stall_mode               = 0;
    stall_phase              = 0;
    stall_mask               = 8'hFF;
    item_bus.valid           = 1'b0;
    item_bus.lead_byte       = 8'h00;
    item_bus.vex_byte1       = 8'h00;
    item_bus.vex_byte2       = 8'h00;
    item_bus.opcode_byte     = 8'h00;
    item_bus.modrm           = 8'h00;
    item_bus.sib_byte        = 8'h00;
    item_bus.available_bytes = 4'd0;
    result_bus.ready         = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    wait_drained();

    burst_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) wait_drained();
      if (burst_left == 0) begin
        idle_sender($urandom_range(1, 8));
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      end
      send_item(random_item());
      burst_left--;
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.expected_lengths.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
